// ===== src/wsrs_pkg.sv =====
// Package for the word stack reverse sort block: modes, status codes,
// controller states and the command/status structs. No dependencies.
package wsrs_pkg;

   localparam logic [1:0] MODE_BYTE = 2'd0;
   localparam logic [1:0] MODE_EOF  = 2'd1;
   localparam logic [1:0] MODE_POP  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   localparam logic [3:0] CSR_MIN_SORT_LENGTH = 4'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY,
      ST_LEN_RD,
      ST_LEN_WAIT,
      ST_LOAD,
      ST_LOAD_WAIT,
      ST_SORT,
      ST_EMIT,
      ST_FLAG
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic append;     // store byte in chunk
      logic clr_chunk;  // reset chunk length
      logic scan_init;  // start push copy
      logic copy_step;  // write one chunk byte to word memory
      logic push_done;  // write length, bump count
      logic pop_dec;    // decrement stack count
      logic len_rd;     // issue length read
      logic load_init;  // start word load
      logic load_step;  // capture one word byte
      logic sort_init;  // start bubble pass
      logic sort_step;  // one compare/swap
      logic emit_init;  // start emission
      logic emit_step;  // advance emission index
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic chunk_full_next; // append fills the chunk
      logic chunk_nonempty;
      logic stack_full;
      logic stack_empty;
      logic copy_done;
      logic len_zero;
      logic load_done;
      logic need_sort;
      logic sort_done;
      logic emit_last;
   } stat_type;

endpackage

// ===== src/wsrs_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface wsrs_if #(parameter int W = 8) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/wsrs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module wsrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== src/wsrs_datapath.sv =====
// Datapath: open chunk, word and length memories, sort buffer and output.
// Depends on wsrs_pkg and wsrs_ram.
module wsrs_datapath import wsrs_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   parameter int WORD_MAX    = 29
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [7:0] byte_in,
   input  logic [3:0] min_sort_length,
   output stat_type   stat,
   output logic [7:0] cur_byte
);
   localparam int LW  = $clog2(WORD_MAX + 1);
   localparam int IW  = $clog2(WORD_MAX);
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int SW  = $clog2(STACK_DEPTH);
   localparam int MD  = STACK_DEPTH * WORD_MAX;
   localparam int MW  = $clog2(MD);

   logic [7:0]    chunk_ff [WORD_MAX];
   logic [LW-1:0] chunk_len_ff, chunk_len_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] idx_ff, idx_in;      // copy/load/emit index
   logic [LW-1:0] scan_len_ff;         // length up to first zero byte
   logic [LW-1:0] scan_len_in;
   logic          scan_hit;            // current copy byte belongs to the word
   logic          scan_stop_ff;
   logic [LW-1:0] wlen_ff;
   logic [7:0]    buf_ff [WORD_MAX];
   logic [LW-1:0] pass_ff, pos_ff;     // bubble limit and position
   logic [LW-1:0] rd_idx_ff;           // index of captured byte

   logic [MW-1:0] base_w, base_r;
   logic [7:0]    byte_rd;
   logic [LW-1:0] len_rd;
   logic [IW-1:0] j_sel;

   assign base_w = MW'(count_ff[SW-1:0] * WORD_MAX);
   assign base_r = MW'(count_ff[SW-1:0] * WORD_MAX);

   // Count a copied byte until the first zero; skip the copy of an empty chunk
   assign scan_hit = cmd.copy_step && !scan_stop_ff && (idx_ff < chunk_len_ff)
                     && chunk_ff[idx_ff[IW-1:0]] != 8'd0;

   always_comb begin
      scan_len_in = scan_len_ff;
      if (scan_hit) scan_len_in = scan_len_ff + LW'(1);
   end

   wsrs_ram #(.WIDTH(8), .DEPTH(MD)) u_bytes (
      .clock   (clock),
      .wr_en   (scan_hit),
      .wr_addr (MW'(base_w + MW'(idx_ff))),
      .wr_data (chunk_ff[idx_ff[IW-1:0]]),
      .rd_addr (MW'(base_r + MW'(idx_ff))),
      .rd_data (byte_rd)
   );

   wsrs_ram #(.WIDTH(LW), .DEPTH(STACK_DEPTH)) u_lens (
      .clock   (clock),
      .wr_en   (cmd.push_done),
      .wr_addr (count_ff[SW-1:0]),
      .wr_data (scan_len_in),
      .rd_addr (count_ff[SW-1:0]),
      .rd_data (len_rd)
   );

   // Chunk byte store
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         chunk_ff[chunk_len_ff[IW-1:0]] <= byte_in;
      end
   end

   // Chunk length and stack count
   always_comb begin
      chunk_len_in = chunk_len_ff;
      if (cmd.append) chunk_len_in = chunk_len_ff + LW'(1);
      if (cmd.clr_chunk) chunk_len_in = '0;
      count_in = count_ff;
      if (cmd.push_done) count_in = count_ff + CW'(1);
      if (cmd.pop_dec) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_len_ff <= '0;
         count_ff     <= '0;
      end else begin
         chunk_len_ff <= chunk_len_in;
         count_ff     <= count_in;
      end
   end

   // Shared index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_init || cmd.load_init || cmd.emit_init) idx_in = '0;
      else if (cmd.copy_step || cmd.load_step || cmd.emit_step) idx_in = idx_ff + LW'(1);
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rd_idx_ff <= idx_ff;
      // Scan for first zero while copying
      if (cmd.scan_init) begin
         scan_len_ff  <= '0;
         scan_stop_ff <= 1'b0;
      end else begin
         scan_len_ff <= scan_len_in;
         if (cmd.copy_step && chunk_ff[idx_ff[IW-1:0]] == 8'd0) scan_stop_ff <= 1'b1;
      end
      if (cmd.len_rd) wlen_ff <= len_rd;
      // Capture read data in the cycle after its address
      if (cmd.load_step && idx_ff != '0) buf_ff[rd_idx_ff[IW-1:0]] <= byte_rd;
      if (cmd.sort_init) begin
         pass_ff <= wlen_ff;
         pos_ff  <= '0;
      end else if (cmd.sort_step) begin
         if (buf_ff[j_sel] > buf_ff[j_sel + IW'(1)]) begin
            buf_ff[j_sel]          <= buf_ff[j_sel + IW'(1)];
            buf_ff[j_sel + IW'(1)] <= buf_ff[j_sel];
         end
         if (pos_ff + LW'(2) >= pass_ff) begin
            pos_ff  <= '0;
            pass_ff <= pass_ff - LW'(1);
         end else begin
            pos_ff <= pos_ff + LW'(1);
         end
      end
   end

   assign j_sel = pos_ff[IW-1:0];

   // Status back to controller
   always_comb begin
      stat.chunk_full_next = (chunk_len_ff + LW'(1)) >= LW'(WORD_MAX);
      stat.chunk_nonempty  = chunk_len_ff != '0;
      stat.stack_full      = count_ff >= CW'(STACK_DEPTH);
      stat.stack_empty     = count_ff == '0;
      stat.copy_done       = idx_ff + LW'(1) >= chunk_len_ff;
      stat.len_zero        = len_rd == '0;
      stat.load_done       = idx_ff == wlen_ff;
      stat.need_sort       = {1'b0, wlen_ff} >= (LW + 1)'(min_sort_length);
      stat.sort_done       = pass_ff < LW'(2);
      stat.emit_last       = idx_ff + LW'(1) == wlen_ff;
   end

   assign cur_byte = buf_ff[idx_ff[IW-1:0]];
endmodule

// ===== src/wsrs_ctrl.sv =====
// Controller state machine: sequences push copy, pop load, sort, emit.
// Depends on wsrs_pkg.
module wsrs_ctrl import wsrs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [1:0] mode,
   input  logic [7:0] byte_in,
   input  stat_type   stat,
   output cmd_type    cmd,
   input  logic [7:0] cur_byte,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_empty,
   output logic       out_last,
   output logic [1:0] out_status
);
   state_type state_ff, state_in;
   logic [1:0] flag_ff, flag_in;
   logic       flag_empty_ff, flag_empty_in;
   logic       acc, close_now, close_full;

   assign acc = in_valid && in_ready;
   // A byte or EOF that closes the open chunk
   assign close_now = (mode == MODE_BYTE && (byte_in == NEWLINE_BYTE || stat.chunk_full_next))
                   || (mode == MODE_EOF && stat.chunk_nonempty);
   assign close_full = close_now && stat.stack_full;

   // Next state
   always_comb begin
      state_in = state_ff;
      flag_in = flag_ff;
      flag_empty_in = flag_empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (mode == MODE_POP) begin
                  if (stat.stack_empty) begin
                     state_in = ST_FLAG; flag_in = STATUS_EMPTY; flag_empty_in = 1'b0;
                  end else state_in = ST_LEN_RD;
               end else if (close_full) begin
                  state_in = ST_FLAG; flag_in = STATUS_FULL; flag_empty_in = 1'b0;
               end else if (close_now) begin
                  state_in = ST_COPY;
               end
            end
         end
         ST_COPY:     if (stat.copy_done) state_in = ST_IDLE;
         ST_LEN_RD:   state_in = ST_LEN_WAIT;
         ST_LEN_WAIT: begin
            if (stat.len_zero) begin
               state_in = ST_FLAG; flag_in = STATUS_OK; flag_empty_in = 1'b1;
            end else state_in = ST_LOAD;
         end
         ST_LOAD:     if (stat.load_done) state_in = ST_LOAD_WAIT;
         ST_LOAD_WAIT: state_in = stat.need_sort ? ST_SORT : ST_EMIT;
         ST_SORT:     if (stat.sort_done) state_in = ST_EMIT;
         ST_EMIT:     if (out_ready && stat.emit_last) state_in = ST_IDLE;
         ST_FLAG:     if (out_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flag_ff <= STATUS_OK;
         flag_empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flag_ff <= flag_in;
         flag_empty_ff <= flag_empty_in;
      end
   end

   // Outputs and datapath commands
   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      out_byte = 8'd0;
      out_empty = 1'b0;
      out_last = 1'b1;
      out_status = STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (acc) begin
               if (mode == MODE_BYTE && byte_in != NEWLINE_BYTE) cmd.append = 1'b1;
               if (close_now) begin
                  cmd.scan_init = 1'b1;
                  if (close_full) cmd.clr_chunk = 1'b1;
               end
               if (mode == MODE_POP && !stat.stack_empty) cmd.pop_dec = 1'b1;
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (stat.copy_done) begin
               cmd.push_done = 1'b1;
               cmd.clr_chunk = 1'b1;
            end
         end
         ST_LEN_RD:   ;
         ST_LEN_WAIT: begin
            cmd.len_rd = 1'b1;
            cmd.load_init = 1'b1;
         end
         ST_LOAD:     cmd.load_step = 1'b1;
         ST_LOAD_WAIT: begin
            cmd.sort_init = 1'b1;
            cmd.emit_init = 1'b1;
         end
         ST_SORT:     cmd.sort_step = !stat.sort_done;
         ST_EMIT: begin
            out_valid = 1'b1;
            out_byte = cur_byte;
            out_last = stat.emit_last;
            cmd.emit_step = out_ready;
         end
         ST_FLAG: begin
            out_valid = 1'b1;
            out_empty = flag_empty_ff;
            out_status = flag_ff;
         end
         default: ;
      endcase
   end
endmodule

// ===== src/word_stack_reverse_sort.sv =====
// Word stack reverse sort: chunks text bytes into words on a stack and pops
// them, sorted when long enough. One word is in flight at a time. Closing a
// chunk copies its bytes up to the first zero into word memory; a pop reads
// the length, loads the word, bubble-sorts it when long enough, then emits
// one byte per cycle while the output is ready; a flag result is one response.
// Synchronous active-high reset empties stack and chunk, sets min_sort_length 5.
module word_stack_reverse_sort import wsrs_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   parameter int WORD_MAX    = 29
) (
   input  logic        clock,
   input  logic        reset,
   wsrs_if.sink        req,
   wsrs_if.source      rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   cmd_type    cmd;
   stat_type   stat;
   logic [7:0] cur_byte;
   logic [3:0] min_sort_ff;

   // Register write
   always_ff @(posedge clock) begin
      if (reset) begin
         min_sort_ff <= 4'd5;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2:2] == CSR_MIN_SORT_LENGTH[0:0]) begin
         min_sort_ff <= csr_pwdata[3:0];
      end
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2:2] == CSR_MIN_SORT_LENGTH[0:0])
                     ? {28'd0, min_sort_ff} : 32'd0;

   wsrs_datapath #(.STACK_DEPTH(STACK_DEPTH), .WORD_MAX(WORD_MAX)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .byte_in(req.data[7:0]),
      .min_sort_length(min_sort_ff), .stat(stat), .cur_byte(cur_byte)
   );

   wsrs_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .mode(req.data[9:8]), .byte_in(req.data[7:0]),
      .stat(stat), .cmd(cmd), .cur_byte(cur_byte),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_byte(rsp.data[7:0]), .out_empty(rsp.data[8]),
      .out_last(rsp.data[9]), .out_status(rsp.data[11:10])
   );
endmodule

// ===== dv/word_stack_reverse_sort_test.sv =====
// Testbench for word_stack_reverse_sort: drives text bytes, end-of-file and pop
// words, predicts the popped byte runs and checks them. Depends on wsrs_pkg,
// wsrs_if and the block itself.
`timescale 1ns / 1ps

module word_stack_reverse_sort_test;
   import wsrs_pkg::*;

   localparam int DEPTH    = 64;
   localparam int WORD_LEN = 29;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] byte_in;
   } req_word_t;

   typedef struct packed {
      logic [1:0] status;
      logic       last;
      logic       empty_word;
      logic [7:0] byte_out;
   } rsp_word_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   wsrs_if #(.W(10)) req ();
   wsrs_if #(.W(12)) rsp ();

   word_stack_reverse_sort u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // predictor state
   logic [7:0] stack_bytes [DEPTH][WORD_LEN];
   logic [4:0] stack_lens [DEPTH];
   int         stack_fill;
   logic [7:0] open_chunk [WORD_LEN];
   int         open_len;
   logic [3:0] sort_min;

   req_word_t pending_words[$];
   rsp_word_t expected_bytes[$];
   int errors = 0, popped_words = 0, checked = 0;
   int idle_cycles = 0;
   bit hold_rsp = 0;
   bit sender_pause = 0;

   function automatic rsp_word_t mk(logic [7:0] b, logic e, logic l, logic [1:0] s);
      rsp_word_t r;
      r.byte_out = b; r.empty_word = e; r.last = l; r.status = s;
      return r;
   endfunction

   // close the open chunk: trim at first zero byte, push or flag full
   function automatic void close_chunk_model();
      int n;
      n = 0;
      while (n < open_len && open_chunk[n] != 8'd0) n++;
      open_len = 0;
      if (stack_fill >= DEPTH) begin
         expected_bytes.push_back(mk(8'd0, 1'b0, 1'b1, STATUS_FULL));
         return;
      end
      for (int i = 0; i < n; i++) stack_bytes[stack_fill][i] = open_chunk[i];
      stack_lens[stack_fill] = n[4:0];
      stack_fill++;
   endfunction

   // pop newest word, sorting it when long enough
   function automatic void pop_model();
      logic [7:0] w [WORD_LEN];
      logic [7:0] t;
      int n;
      if (stack_fill == 0) begin
         expected_bytes.push_back(mk(8'd0, 1'b0, 1'b1, STATUS_EMPTY));
         return;
      end
      stack_fill--;
      n = int'(stack_lens[stack_fill]);
      popped_words++;
      if (n == 0) begin
         expected_bytes.push_back(mk(8'd0, 1'b1, 1'b1, STATUS_OK));
         return;
      end
      for (int i = 0; i < n; i++) w[i] = stack_bytes[stack_fill][i];
      if (n >= sort_min)
         for (int i = 0; i < n; i++)
            for (int j = 0; j + 1 < n - i; j++)
               if (w[j] > w[j+1]) begin
                  t = w[j]; w[j] = w[j+1]; w[j+1] = t;
               end
      for (int i = 0; i < n; i++)
         expected_bytes.push_back(mk(w[i], 1'b0, i == n - 1, STATUS_OK));
   endfunction

   function automatic void predict_word(req_word_t it);
      case (it.mode)
         MODE_BYTE: begin
            if (it.byte_in == NEWLINE_BYTE) begin
               close_chunk_model();
            end else begin
               if (open_len < WORD_LEN) begin
                  open_chunk[open_len] = it.byte_in;
                  open_len++;
               end
               if (open_len >= WORD_LEN) close_chunk_model();
            end
         end
         MODE_EOF: if (open_len > 0) close_chunk_model();
         MODE_POP: pop_model();
         default: ;
      endcase
   endfunction

   // driver: bursts and gaps, predicts on acceptance
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         req.data <= '0;
      end else begin
         if (req.valid && req.ready) begin
            predict_word(req_word_t'(req.data));
            void'(pending_words.pop_front());
         end
         if (gap_left > 0) gap_left--;
         if (req.valid && req.ready && burst_left > 0) burst_left--;
         if (burst_left == 0 && gap_left == 0 && !(req.valid && !req.ready)) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 30);
         end
         if (req.valid && !req.ready) begin
            // hold the current word
         end else if (pending_words.size() > (req.valid && req.ready ? 0 : 0)
                      && !sender_pause && gap_left == 0) begin
            req.valid <= 1;
            req.data <= pending_words[0];
         end else begin
            req.valid <= 0;
         end
      end
   end

   // receiver stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         stall_phase = (stall_phase + 1) % 23;
         rsp.ready <= !hold_rsp && (stall_phase < 12 ? 1'b1 : ($urandom_range(0, 2) != 0));
      end
   end

   // monitor: compare each accepted byte with the oldest expectation
   always @(posedge clock) begin
      rsp_word_t got, want;
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp.valid && rsp.ready) begin
            got = rsp_word_t'(rsp.data);
            if (expected_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected result %h", $time, got);
            end else begin
               want = expected_bytes.pop_front();
               checked++;
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch expected byte=%h empty=%b last=%b status=%0d",
                           $time, want.byte_out, want.empty_word, want.last, want.status);
                  $display("%0t:          actual   byte=%h empty=%b last=%b status=%0d",
                           $time, got.byte_out, got.empty_word, got.last, got.status);
               end
            end
         end
         if (idle_cycles > WATCHDOG) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     expected_bytes.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic add(logic [1:0] m, logic [7:0] b);
      req_word_t it;
      it.mode = m; it.byte_in = b;
      pending_words.push_back(it);
   endtask

   task automatic add_random_word(int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom_range(0, 255));
         if (b == NEWLINE_BYTE || (b == 8'd0 && $urandom_range(0, 7) != 0)) b = 8'h41 + 8'(i);
         add(MODE_BYTE, b);
      end
      if (n < WORD_LEN) begin
         if ($urandom_range(0, 1)) add(MODE_BYTE, NEWLINE_BYTE);
         else add(MODE_EOF, 8'($urandom_range(0, 255)));
      end
   endtask

   // drain: feed all, wait for all results, then let the block settle
   task automatic drain();
      wait (pending_words.size() == 0 && !req.valid);
      wait (expected_bytes.size() == 0);
      repeat (1200) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] idx, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx[0], 2'b00}; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      sort_min = v[3:0];
   endtask

   initial begin
      stack_fill = 0; open_len = 0; sort_min = 4'd5;
      req.valid = 0; req.data = '0; rsp.ready = 0;
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: pop empty, empty word, zero byte, full chunk, extremes, mode 3
      add(MODE_POP, 8'hFF);
      add(MODE_EOF, 8'h00);
      add(MODE_BYTE, NEWLINE_BYTE);
      add(MODE_POP, 8'h00);
      add(MODE_BYTE, 8'hFF); add(MODE_BYTE, 8'h00); add(MODE_BYTE, 8'h7F);
      add(MODE_BYTE, 8'h80); add(MODE_EOF, 8'h55);
      add(MODE_POP, 8'h00);
      add(MODE_BYTE, 8'hFF); add(MODE_BYTE, 8'h80); add(MODE_BYTE, 8'h01);
      add(MODE_BYTE, 8'h7F); add(MODE_BYTE, 8'h00 + 8'd2); add(MODE_BYTE, NEWLINE_BYTE);
      add(MODE_POP, 8'h00);
      add(2'd3, 8'hAA);
      add_random_word(WORD_LEN);
      add(MODE_POP, 8'h00);
      drain();

      // sweep the threshold through its extremes with random traffic
      foreach (pending_words[i]) ;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: csr_write(CSR_MIN_SORT_LENGTH, 0);
            1: csr_write(CSR_MIN_SORT_LENGTH, 15);
            2: csr_write(CSR_MIN_SORT_LENGTH, 5);
            3: csr_write(CSR_MIN_SORT_LENGTH, $urandom_range(1, 14));
            default: csr_write(CSR_MIN_SORT_LENGTH, 32'd9);
         endcase
         for (int k = 0; k < 5; k++) begin
            if ($urandom_range(0, 3) == 0) add_random_word($urandom_range(0, WORD_LEN));
            else add_random_word($urandom_range(1, 10));
            if ($urandom_range(0, 2) != 0) add(MODE_POP, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0)
               add(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
         for (int k = 0; k < 3; k++) add(MODE_POP, 8'h00);
         if (phase == 2) begin
            // long receiver hold while sender keeps offering
            fork
               begin
                  hold_rsp = 1;
                  repeat (600) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         drain();
      end

      // fill the stack past full, then empty it past empty
      csr_write(CSR_MIN_SORT_LENGTH, 32'd3);
      for (int k = 0; k < DEPTH + 2; k++) add(MODE_BYTE, NEWLINE_BYTE);
      add(MODE_BYTE, 8'h31); add(MODE_EOF, 8'h00);
      for (int k = 0; k < DEPTH + 2; k++) add(MODE_POP, 8'h00);
      drain();

      $display("Covered %0d checked results, %0d popped words, thresholds 0..15,",
               checked, popped_words);
      $display("full and empty stack, zero bytes, chunk overflow and long output stalls.");
      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // sender pause until everything has drained, once mid-run
   initial begin
      wait (popped_words > 20);
      sender_pause = 1;
      wait (expected_bytes.size() == 0);
      sender_pause = 0;
   end
endmodule
